// File: rtl/core/tqbp_pkg.sv
// Package for the ternary quantiser and bit-plane packer.
// Holds fixed field widths, CSR reset values and CSR register indexes.
// No dependencies; used by the top level and its checker.
package tqbp_pkg;

   // Payload field widths
   localparam int SAMPLE_W   = 16;
   localparam int PLANE_W    = 64;
   localparam int WORD_NUM_W = 4;

   // CSR port widths and register fields
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int COUNT_W     = 11;
   localparam int THRESH_W    = 15;

   // Reset values of the CSRs
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 11'd64;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd0;

   // CSR register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 8'd0,
      CSR_THRESHOLD     = 8'd1
   } csr_index_type;

endpackage

// File: rtl/core/ternary_quantize_bitplane_pack.sv
// The word pair shows on the rsp_ port in the cycle after the transfer of the
// sample that fills a word or ends a pixel.
// Throughput: one sample per cycle; req_stall rises only while a finished word
// pair is held by rsp_stall, as the single result register is then occupied.
// Reset (synchronous, active high): planes and position cleared, channel_count
// back to 64, threshold back to 0, no result pending.
// Depends on tqbp_pkg.
module ternary_quantize_bitplane_pack #(
   parameter int WORD_BITS    = 64,
   parameter int MAX_CHANNELS = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [tqbp_pkg::SAMPLE_W-1:0]   req_sample,
   // word pair channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tqbp_pkg::PLANE_W-1:0]           rsp_negative_plane,
   output logic [tqbp_pkg::PLANE_W-1:0]           rsp_nonzero_plane,
   output logic [tqbp_pkg::WORD_NUM_W-1:0]        rsp_word_number,
   output logic                                   rsp_pixel_end,
   // CSR write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tqbp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tqbp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int BIT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int POS_W = $clog2(MAX_CHANNELS);
   localparam int CMP_W = ($clog2(MAX_CHANNELS + 1) > tqbp_pkg::COUNT_W + 1)
                          ? $clog2(MAX_CHANNELS + 1) : tqbp_pkg::COUNT_W + 1;
   localparam int TCMP_W = tqbp_pkg::THRESH_W + 2;

   localparam logic [BIT_W-1:0] LAST_BIT  = BIT_W'(WORD_BITS - 1);
   localparam logic [CMP_W-1:0] MAX_COUNT = CMP_W'(MAX_CHANNELS);

   // CSRs
   logic [tqbp_pkg::COUNT_W-1:0]  count_ff;
   logic [tqbp_pkg::THRESH_W-1:0] thresh_ff;

   // packing state
   logic [WORD_BITS-1:0]            neg_acc_ff, neg_acc_in;
   logic [WORD_BITS-1:0]            nz_acc_ff, nz_acc_in;
   logic [POS_W-1:0]                pos_ff, pos_in;
   logic [BIT_W-1:0]                bit_ff, bit_in;
   logic [tqbp_pkg::WORD_NUM_W-1:0] word_ff, word_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [tqbp_pkg::PLANE_W-1:0]    rsp_neg_ff;
   logic [tqbp_pkg::PLANE_W-1:0]    rsp_nz_ff;
   logic [tqbp_pkg::WORD_NUM_W-1:0] rsp_word_ff;
   logic                            rsp_end_ff;

   logic                            req_xfer;
   logic                            emit;
   logic                            is_last;
   logic                            is_full;
   logic                            above;
   logic                            below;
   logic [CMP_W-1:0]                eff_count;
   logic [CMP_W-1:0]                pos_next;
   logic [WORD_BITS-1:0]            bit_mask;
   logic signed [TCMP_W-1:0]        sample_ext;
   logic signed [TCMP_W-1:0]        thresh_pos;
   logic signed [TCMP_W-1:0]        thresh_neg;

   assign csr_ready = 1'b1;

   // CSR writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= tqbp_pkg::COUNT_RESET;
         thresh_ff <= tqbp_pkg::THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tqbp_pkg::CSR_CHANNEL_COUNT: count_ff  <= csr_wdata[tqbp_pkg::COUNT_W-1:0];
            tqbp_pkg::CSR_THRESHOLD:     thresh_ff <= csr_wdata[tqbp_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: hold off only while the result register is stuck
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   // Ternary compare, exact on Q8.8 integers
   always_comb begin
      sample_ext = TCMP_W'(req_sample);
      thresh_pos = $signed({2'b00, thresh_ff});
      thresh_neg = -thresh_pos;
      above      = sample_ext > thresh_pos;
      below      = sample_ext < thresh_neg;
   end

   // Word and pixel boundary detection
   always_comb begin
      eff_count = CMP_W'(count_ff);
      if (count_ff == '0) begin
         eff_count = CMP_W'(1);
      end
      if (eff_count > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end
      pos_next = CMP_W'(pos_ff) + CMP_W'(1);
      is_last  = pos_next >= eff_count;
      is_full  = bit_ff == LAST_BIT;
      emit     = req_xfer && (is_last || is_full);
   end

   // Bit set into the accumulators, next packing state
   always_comb begin
      bit_mask   = WORD_BITS'(1) << bit_ff;
      neg_acc_in = neg_acc_ff;
      nz_acc_in  = nz_acc_ff;
      pos_in     = pos_ff;
      bit_in     = bit_ff;
      word_in    = word_ff;
      if (above) begin
         nz_acc_in = nz_acc_ff | bit_mask;
      end else if (below) begin
         neg_acc_in = neg_acc_ff | bit_mask;
         nz_acc_in  = nz_acc_ff | bit_mask;
      end
      if (!req_xfer) begin
         neg_acc_in = neg_acc_ff;
         nz_acc_in  = nz_acc_ff;
      end else if (is_last) begin
         pos_in  = '0;
         bit_in  = '0;
         word_in = '0;
      end else begin
         pos_in = pos_next[POS_W-1:0];
         if (is_full) begin
            bit_in  = '0;
            word_in = word_ff + tqbp_pkg::WORD_NUM_W'(1);
         end else begin
            bit_in = bit_ff + BIT_W'(1);
         end
      end
   end

   // Packing state registers; accumulators clear once a word leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         neg_acc_ff <= '0;
         nz_acc_ff  <= '0;
         pos_ff     <= '0;
         bit_ff     <= '0;
         word_ff    <= '0;
      end else begin
         neg_acc_ff <= emit ? '0 : neg_acc_in;
         nz_acc_ff  <= emit ? '0 : nz_acc_in;
         pos_ff     <= pos_in;
         bit_ff     <= bit_in;
         word_ff    <= word_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_neg_ff  <= tqbp_pkg::PLANE_W'(neg_acc_in);
         rsp_nz_ff   <= tqbp_pkg::PLANE_W'(nz_acc_in);
         rsp_word_ff <= word_ff;
         rsp_end_ff  <= is_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_negative_plane = rsp_neg_ff;
   assign rsp_nonzero_plane  = rsp_nz_ff;
   assign rsp_word_number    = rsp_word_ff;
   assign rsp_pixel_end      = rsp_end_ff;

endmodule

// File: rtl/core/tqbp_checker.sv
// Port-level checks for the ternary quantiser and bit-plane packer.
// Depends on tqbp_pkg; bound to ternary_quantize_bitplane_pack below.
module tqbp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [tqbp_pkg::PLANE_W-1:0]         rsp_negative_plane,
   input logic [tqbp_pkg::PLANE_W-1:0]         rsp_nonzero_plane,
   input logic [tqbp_pkg::WORD_NUM_W-1:0]      rsp_word_number,
   input logic                                 rsp_pixel_end
);

   // nothing pending straight after reset
   a_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid after reset");

   // input only held back while a result is stuck
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // a negative bit always carries its nonzero bit
   a_plane_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_negative_plane & ~rsp_nonzero_plane) == '0))
      else $error("negative bit without nonzero bit");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_negative_plane)
         && $stable(rsp_nonzero_plane) && $stable(rsp_word_number)
         && $stable(rsp_pixel_end)))
      else $error("result payload changed while stalled");

endmodule

bind ternary_quantize_bitplane_pack tqbp_checker u_tqbp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_negative_plane (rsp_negative_plane),
   .rsp_nonzero_plane  (rsp_nonzero_plane),
   .rsp_word_number    (rsp_word_number),
   .rsp_pixel_end      (rsp_pixel_end)
);
